// ===== sv/crast_pkg.sv =====
// Shared types and constants of the circle rasterizer.
`default_nettype none
package crast_pkg;

	localparam int CENTER_W   = 12;
	localparam int RADIUS_W   = 11;
	localparam int OFFSET_W   = 12;
	localparam int DECISION_W = 14;
	localparam int OUT_W      = 14;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// Input item opcodes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Register index as decoded from paddr[2].
	localparam logic REG_FILL_MODE = 1'b0;

	// One iteration handed from the front end to the emitter.
	typedef struct packed {
		logic [CENTER_W-1:0] cx;
		logic [CENTER_W-1:0] cy;
		logic [OFFSET_W-1:0] ox;
		logic [OFFSET_W-1:0] oy;
		logic                fill;
		logic                done;
	} job_t;

endpackage
`default_nettype wire

// ===== sv/crast_front.sv =====
// Front end: takes start and step items, runs the Andres iteration, issues jobs.
`default_nettype none
module crast_front #(
	parameter int COORD_WIDTH = 12
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 accept,
	input  wire                                 op,
	input  wire  [crast_pkg::CENTER_W-1:0]      center_x,
	input  wire  [crast_pkg::CENTER_W-1:0]      center_y,
	input  wire  [crast_pkg::RADIUS_W-1:0]      radius,
	input  wire                                 fill_mode,
	output logic                                job_valid,
	output crast_pkg::job_t                     job
);

	localparam logic [crast_pkg::CENTER_W-1:0] CENTER_MASK =
		(COORD_WIDTH >= crast_pkg::CENTER_W) ? {crast_pkg::CENTER_W{1'b1}} :
		crast_pkg::CENTER_W'((1 << COORD_WIDTH) - 1);

	logic [crast_pkg::CENTER_W-1:0]   cx_q, cy_q;
	logic [crast_pkg::RADIUS_W-1:0]   rad_q;
	logic [crast_pkg::OFFSET_W-1:0]   ox_q, oy_q;
	logic [crast_pkg::DECISION_W-1:0] dec_q;
	logic                             busy_q;

	logic signed [15:0] d_w, ox_w, oy_w, rad_w;
	logic signed [15:0] d_next, ox_next, oy_next;
	logic               done;
	logic               is_step;

	always_comb begin
		d_w   = 16'($signed(dec_q));
		ox_w  = $signed({4'b0, ox_q});
		oy_w  = $signed({4'b0, oy_q});
		rad_w = $signed({5'b0, rad_q});
		if (d_w >= (ox_w <<< 1)) begin
			d_next  = d_w - (ox_w <<< 1) - 16'sd1;
			ox_next = ox_w + 16'sd1;
			oy_next = oy_w;
		end else if (d_w < ((rad_w - oy_w) <<< 1)) begin
			d_next  = d_w + (oy_w <<< 1) - 16'sd1;
			ox_next = ox_w;
			oy_next = oy_w - 16'sd1;
		end else begin
			d_next  = d_w + ((oy_w - ox_w - 16'sd1) <<< 1);
			ox_next = ox_w + 16'sd1;
			oy_next = oy_w - 16'sd1;
		end
		done = oy_next < ox_next;
	end

	assign is_step   = accept && (op == crast_pkg::OP_STEP);
	assign job_valid = is_step && busy_q;

	always_comb begin
		job.cx   = cx_q;
		job.cy   = cy_q;
		job.ox   = ox_q;
		job.oy   = oy_q;
		job.fill = fill_mode;
		job.done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			rad_q  <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			dec_q  <= '0;
			busy_q <= 1'b0;
		end else if (accept && (op == crast_pkg::OP_START)) begin
			cx_q   <= center_x & CENTER_MASK;
			cy_q   <= center_y & CENTER_MASK;
			rad_q  <= radius;
			ox_q   <= '0;
			oy_q   <= {1'b0, radius};
			dec_q  <= crast_pkg::DECISION_W'({3'b0, radius}) - 14'd1;
			busy_q <= 1'b1;
		end else if (job_valid) begin
			ox_q  <= ox_next[crast_pkg::OFFSET_W-1:0];
			oy_q  <= oy_next[crast_pkg::OFFSET_W-1:0];
			dec_q <= d_next[crast_pkg::DECISION_W-1:0];
			// drop the circle once the row offset falls below the column offset
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/crast_queue.sv =====
// Two-entry job queue between the front end and the emitter.
`default_nettype none
module crast_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  crast_pkg::job_t  push_data,
	input  wire              pop,
	output crast_pkg::job_t  pop_data,
	output logic             full,
	output logic             valid
);

	crast_pkg::job_t entry_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/crast_back.sv =====
// Emitter: expands one job into eight points or four spans, one item per cycle while pop keeps the result port free.
`default_nettype none
module crast_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  q_valid,
	input  crast_pkg::job_t                      q_data,
	output logic                                 q_pop,
	input  wire                                  pop,
	output logic                                 empty,
	output logic signed [crast_pkg::OUT_W-1:0]   x_start,
	output logic signed [crast_pkg::OUT_W-1:0]   x_end,
	output logic signed [crast_pkg::OUT_W-1:0]   row,
	output logic                                 last_of_step,
	output logic                                 finished
);

	crast_pkg::job_t cur_q;
	logic            cur_valid_q;
	logic [2:0]      idx_q;
	logic            out_valid_q;

	logic                        out_free, cur_last, advance;
	logic [crast_pkg::OUT_W-1:0] cx, cy, ox, oy, a, b, xs, xe, rw;
	logic                        swap;

	always_comb begin
		cx   = {2'b0, cur_q.cx};
		cy   = {2'b0, cur_q.cy};
		ox   = {2'b0, cur_q.ox};
		oy   = {2'b0, cur_q.oy};
		swap = 1'b0;
		a    = '0;
		b    = '0;
		xs   = '0;
		xe   = '0;
		rw   = '0;
		if (cur_q.fill) begin
			// middle two spans use the column offset as half-width
			swap = idx_q[0] ^ idx_q[1];
			a    = swap ? ox : oy;
			b    = swap ? oy : ox;
			xs   = cx - a;
			xe   = cx + a;
			rw   = idx_q[1] ? cy - b : cy + b;
		end else begin
			a  = idx_q[0] ? oy : ox;
			b  = idx_q[0] ? ox : oy;
			xs = idx_q[1] ? cx - a : cx + a;
			xe = xs;
			rw = idx_q[2] ? cy - b : cy + b;
		end
		cur_last = cur_q.fill ? (idx_q == 3'd3) : (idx_q == 3'd7);
	end

	assign out_free = !out_valid_q || pop;
	assign advance  = out_free && cur_valid_q;
	assign q_pop    = q_valid && (!cur_valid_q || (advance && cur_last));
	assign empty    = !out_valid_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			x_start      <= $signed(xs);
			x_end        <= $signed(xe);
			row          <= $signed(rw);
			last_of_step <= cur_last;
			finished     <= cur_q.done;
		end
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= cur_valid_q;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance && cur_last) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/circle_rasterizer.sv =====
// A step item's job passes through the job queue and the emitter's current-job register before
// its first result is registered on the result ports. Throughput: results leave at one per cycle
// while pop keeps the result port free; a step gives 8 (outline) or 4 (fill) of them.
// Start items and idle steps give no results; a two-entry job queue absorbs bursts.
// Reset (arst_n low, asynchronous): no circle active, queue and result port empty,
// fill_mode cleared to outline.
`default_nettype none
module circle_rasterizer #(
	parameter int COORD_WIDTH = 12
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   push,
	output logic                                  full,
	input  wire                                   op,
	input  wire  [crast_pkg::CENTER_W-1:0]        center_x,
	input  wire  [crast_pkg::CENTER_W-1:0]        center_y,
	input  wire  [crast_pkg::RADIUS_W-1:0]        radius,
	output logic                                  empty,
	input  wire                                   pop,
	output logic signed [crast_pkg::OUT_W-1:0]    x_start,
	output logic signed [crast_pkg::OUT_W-1:0]    x_end,
	output logic signed [crast_pkg::OUT_W-1:0]    row,
	output logic                                  last_of_step,
	output logic                                  finished,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [crast_pkg::PADDR_W-1:0]         paddr,
	input  wire  [crast_pkg::PDATA_W-1:0]         pwdata,
	output logic [crast_pkg::PDATA_W-1:0]         prdata,
	output logic                                  pready
);

	logic            fill_mode_q;
	logic            accept;
	logic            job_valid;
	crast_pkg::job_t job, q_data;
	logic            q_pop, q_valid;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == crast_pkg::REG_FILL_MODE) ?
		{{(crast_pkg::PDATA_W-1){1'b0}}, fill_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == crast_pkg::REG_FILL_MODE)) begin
			fill_mode_q <= pwdata[0];
		end
	end

	assign accept = push && !full;

	crast_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.fill_mode (fill_mode_q),
		.job_valid (job_valid),
		.job       (job)
	);

	crast_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_data (job),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (full),
		.valid     (q_valid)
	);

	crast_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.x_start      (x_start),
		.x_end        (x_end),
		.row          (row),
		.last_of_step (last_of_step),
		.finished     (finished)
	);

endmodule
`default_nettype wire

// ===== sv/crast_checker.sv =====
// Port-level checks of the circle rasterizer and their binding.
`default_nettype none
module crast_checker (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   empty,
	input wire                                   pop,
	input wire  signed [crast_pkg::OUT_W-1:0]    x_start,
	input wire  signed [crast_pkg::OUT_W-1:0]    x_end,
	input wire  signed [crast_pkg::OUT_W-1:0]    row,
	input wire                                   last_of_step,
	input wire                                   finished
);

	// Nothing waits on the result side while in reset.
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result waiting during reset");

	// A stalled item holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(x_start) && $stable(x_end) &&
		$stable(row) && $stable(last_of_step) && $stable(finished)))
		else $error("stalled result changed");

	// Within a step, the next item follows the taken one without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_step) |=> !empty)
		else $error("gap inside a step");

	// Spans never run right to left; points have equal ends.
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (x_start <= x_end))
		else $error("span ends out of order");

endmodule

bind circle_rasterizer crast_checker u_crast_checker (.*);
`default_nettype wire
